/* rtl/ccfr_pkg.sv */
// Shared types, constants and the CRC-16 byte update for the framed receiver.
package ccfr_pkg;

  localparam int unsigned MAX_PAYLOAD = 4096;

  localparam logic [7:0]  START0_BYTE  = 8'hAA;
  localparam logic [7:0]  START1_BYTE  = 8'h55;
  localparam logic [7:0]  END0_BYTE    = 8'h55;
  localparam logic [7:0]  END1_BYTE    = 8'hAA;
  localparam logic [7:0]  REPLY_ACK    = 8'h06;
  localparam logic [7:0]  REPLY_NAK    = 8'h15;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'h1021;

  localparam logic [12:0] LEN_RESET     = 13'd1458;
  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
  localparam logic [12:0] MAX_LEN       = 13'(MAX_PAYLOAD);

  typedef enum logic [3:0] {
    PH_START0 = 4'd0,
    PH_START1 = 4'd1,
    PH_LEN_HI = 4'd2,
    PH_LEN_LO = 4'd3,
    PH_DATA   = 4'd4,
    PH_CRC_HI = 4'd5,
    PH_CRC_LO = 4'd6,
    PH_END0   = 4'd7,
    PH_END1   = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRC     = 2'd1,
    ST_SYNC    = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_e;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_e;

  typedef enum logic {
    REG_EXPECTED_LENGTH = 1'b0,
    REG_TIMEOUT_TICKS   = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [11:0] byte_index;
    logic [1:0]  status;
    logic        reply_valid;
    logic [7:0]  reply_byte;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/crc_checked_frame_receiver_core.sv */
// Framed packet receiver core: marker hunt, length check, CRC-16 check, output buffer.
// Takes one item (received byte or time tick) per clock cycle while in_stall_o is low.
// The frame state and CRC-16/CCITT-FALSE update for a byte are registered on accept;
// its result goes to the output register, or to the skid register if the output stalls.
// A two-entry output buffer (output register plus skid register) lets input keep flowing
// while a result waits; in_stall_o rises only when both entries hold results. Payload
// bytes are released before the frame is verified, so commit them only on an ok status.
module crc_checked_frame_receiver_core
  import ccfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  data_byte_o,
  output logic [11:0] byte_index_o,
  output logic [1:0]  status_o,
  output logic        reply_valid_o,
  output logic [7:0]  reply_byte_o
);

  logic [12:0] exp_len_q;
  logic [15:0] timeout_q;

  phase_e      phase_q, phase_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [12:0] cnt_q, cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] rx_crc_q, rx_crc_d;
  logic        end_ok_q, end_ok_d;
  logic [15:0] elapsed_q, elapsed_d;

  result_t     res;
  logic        res_valid;
  logic        attempt_end;
  logic        in_acc;
  logic [12:0] cnt_inc;

  result_t     out_q, out_d, skid_q, skid_d;
  logic        out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic        out_free;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cnt_inc     = cnt_q + 13'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q <= LEN_RESET;
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_EXPECTED_LENGTH: exp_len_q <= cfg_data_i[12:0];
        REG_TIMEOUT_TICKS:   timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d     = phase_q;
    len_hi_d    = len_hi_q;
    cnt_d       = cnt_q;
    crc_d       = crc_q;
    rx_crc_d    = rx_crc_q;
    end_ok_d    = end_ok_q;
    elapsed_d   = elapsed_q;
    res         = '0;
    res_valid   = 1'b0;
    attempt_end = 1'b0;
    if (in_acc) begin
      if (cmd_e'(cmd_i) == CMD_TICK) begin
        if (elapsed_q >= timeout_q) begin
          res_valid   = 1'b1;
          res.kind    = KIND_STATUS;
          res.status  = ST_TIMEOUT;
          attempt_end = 1'b1;
        end else begin
          elapsed_d = elapsed_q + 16'd1;
        end
      end else begin
        unique case (phase_q)
          PH_START0: begin
            if (rx_byte_i == START0_BYTE) phase_d = PH_START1;
          end
          PH_START1: begin
            phase_d = (rx_byte_i == START1_BYTE) ? PH_LEN_HI : PH_START0;
          end
          PH_LEN_HI: begin
            len_hi_d = rx_byte_i;
            phase_d  = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            if ({len_hi_q, rx_byte_i} != {3'b000, exp_len_q} || exp_len_q > MAX_LEN) begin
              res_valid       = 1'b1;
              res.kind        = KIND_STATUS;
              res.status      = ST_SYNC;
              res.reply_valid = 1'b1;
              res.reply_byte  = REPLY_NAK;
              attempt_end     = 1'b1;
            end else begin
              cnt_d   = '0;
              crc_d   = CRC_INIT;
              phase_d = (exp_len_q == '0) ? PH_CRC_HI : PH_DATA;
            end
          end
          PH_DATA: begin
            res_valid      = 1'b1;
            res.kind       = KIND_PAYLOAD;
            res.data_byte  = rx_byte_i;
            res.byte_index = cnt_q[11:0];
            crc_d          = crc_byte(crc_q, rx_byte_i);
            cnt_d          = cnt_inc;
            if (cnt_inc >= exp_len_q) phase_d = PH_CRC_HI;
          end
          PH_CRC_HI: begin
            rx_crc_d = {rx_byte_i, 8'h00};
            phase_d  = PH_CRC_LO;
          end
          PH_CRC_LO: begin
            rx_crc_d = {rx_crc_q[15:8], rx_byte_i};
            phase_d  = PH_END0;
          end
          PH_END0: begin
            end_ok_d = (rx_byte_i == END0_BYTE);
            phase_d  = PH_END1;
          end
          PH_END1: begin
            res_valid       = 1'b1;
            res.kind        = KIND_STATUS;
            res.reply_valid = 1'b1;
            attempt_end     = 1'b1;
            if (!end_ok_q || rx_byte_i != END1_BYTE) begin
              res.status     = ST_SYNC;
              res.reply_byte = REPLY_NAK;
            end else if (crc_q != rx_crc_q) begin
              res.status     = ST_CRC;
              res.reply_byte = REPLY_NAK;
            end else begin
              res.status     = ST_OK;
              res.reply_byte = REPLY_ACK;
            end
          end
          default: begin
            attempt_end = 1'b1;
          end
        endcase
      end
      if (attempt_end) begin
        phase_d   = PH_START0;
        len_hi_d  = '0;
        cnt_d     = '0;
        crc_d     = CRC_INIT;
        rx_crc_d  = '0;
        end_ok_d  = 1'b0;
        elapsed_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_START0;
      len_hi_q  <= '0;
      cnt_q     <= '0;
      crc_q     <= CRC_INIT;
      rx_crc_q  <= '0;
      end_ok_q  <= 1'b0;
      elapsed_q <= '0;
    end else begin
      phase_q   <= phase_d;
      len_hi_q  <= len_hi_d;
      cnt_q     <= cnt_d;
      crc_q     <= crc_d;
      rx_crc_q  <= rx_crc_d;
      end_ok_q  <= end_ok_d;
      elapsed_q <= elapsed_d;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res;
        out_valid_d = res_valid;
      end
    end else if (res_valid) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_q.kind;
  assign data_byte_o   = out_q.data_byte;
  assign byte_index_o  = out_q.byte_index;
  assign status_o      = out_q.status;
  assign reply_valid_o = out_q.reply_valid;
  assign reply_byte_o  = out_q.reply_byte;

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a result while output register is empty");

  a_payload_no_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_PAYLOAD) |-> (!reply_valid_o && status_o == ST_OK))
    else $error("payload transfer carries reply or status");

  a_timeout_no_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_STATUS && status_o == ST_TIMEOUT) |-> !reply_valid_o)
    else $error("timeout status carries a reply");

  a_status_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.kind == KIND_STATUS) |=> (phase_q == PH_START0 && elapsed_q == '0))
    else $error("attempt state not cleared after status");

  a_no_loss_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && out_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("result dropped while output stalled");
`endif

endmodule
